// ===== rtl/sacl_pkg.sv =====
// Shared constants, codes and types of the set-associative LRU cache tag store.
package sacl_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int NUM_SETS   = 1 << MAX_SET_BITS;
    localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W     = WAY_W;
    localparam int ADDR_W     = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SETB_W     = 3;
    localparam int WAYS_CFG_W = 4;
    localparam int OFFS_W     = 6;
    localparam int SUM_W      = OFFS_W + 1;

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] address;
    } t_in;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             final_of_run;
        logic [CNT_W-1:0] total_hits;
        logic [CNT_W-1:0] total_misses;
        logic [CNT_W-1:0] total_evictions;
    } t_out;

    typedef struct packed {
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } t_row;

    typedef struct packed {
        logic                en;
        logic [SET_W-1:0]    set;
        logic [MAX_WAYS-1:0] valid;
        t_row                row;
    } t_store_wr;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  hit_way;
        logic [RANK_W-1:0] hit_rank;
        logic              inv;
        logic [WAY_W-1:0]  inv_way;
        logic [WAY_W-1:0]  victim;
    } t_scan_res;

endpackage

// ===== rtl/sacl_tag_store.sv =====
// Tag, rank and valid memories, one row per set, with a clearing pass after reset.
module sacl_tag_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [sacl_pkg::SET_W-1:0]    i_rd_set,
    input  sacl_pkg::t_store_wr           i_wr,
    output sacl_pkg::t_row                o_rd_row,
    output logic [sacl_pkg::MAX_WAYS-1:0] o_rd_valid,
    output logic                          o_ready
);
    import sacl_pkg::*;

    t_row                mem       [NUM_SETS];
    logic [MAX_WAYS-1:0] mem_valid [NUM_SETS];
    t_row                r_rd_row;
    logic [MAX_WAYS-1:0] r_rd_valid;
    logic                r_clearing;
    logic [SET_W-1:0]    r_clr_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_set  <= '0;
        end else if (r_clearing) begin
            r_clr_set <= r_clr_set + SET_W'(1);
            if (r_clr_set == SET_W'(NUM_SETS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.set] <= i_wr.row;
        end
        if (i_rd_en) begin
            r_rd_row <= mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem_valid[r_clr_set] <= '0;
        end else if (i_wr.en) begin
            mem_valid[i_wr.set] <= i_wr.valid;
        end
        if (i_rd_en) begin
            r_rd_valid <= mem_valid[i_rd_set];
        end
    end

    assign o_rd_row   = r_rd_row;
    assign o_rd_valid = r_rd_valid;
    assign o_ready    = !r_clearing;

endmodule

// ===== rtl/sacl_way_scan.sv =====
// Shared tag comparator that walks the ways of one set, one way per cycle.
module sacl_way_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic                          i_step,
    input  logic [sacl_pkg::WAY_W-1:0]    i_way,
    input  logic [sacl_pkg::ADDR_W-1:0]   i_key,
    input  sacl_pkg::t_row                i_row,
    input  logic [sacl_pkg::MAX_WAYS-1:0] i_valid,
    output sacl_pkg::t_scan_res           o_res
);
    import sacl_pkg::*;

    t_scan_res         r_res;
    logic [RANK_W-1:0] r_max_rank;
    logic              w_v;
    logic [ADDR_W-1:0] w_tag;
    logic [RANK_W-1:0] w_rank;
    logic              w_match;

    assign w_v     = i_valid[i_way];
    assign w_tag   = i_row.tag[i_way];
    assign w_rank  = i_row.rank[i_way];
    assign w_match = w_v && (w_tag == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res      <= '0;
            r_max_rank <= '0;
        end else if (i_clr) begin
            r_res.hit    <= 1'b0;
            r_res.inv    <= 1'b0;
            r_res.victim <= '0;
            r_max_rank   <= '0;
        end else if (i_step) begin
            if (!r_res.hit && w_match) begin
                r_res.hit      <= 1'b1;
                r_res.hit_way  <= i_way;
                r_res.hit_rank <= w_rank;
            end
            if (!r_res.inv && !w_v) begin
                r_res.inv     <= 1'b1;
                r_res.inv_way <= i_way;
            end
            if ((i_way == '0) || (w_rank > r_max_rank)) begin
                r_res.victim <= i_way;
                r_max_rank   <= w_rank;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/set_assoc_cache_lru_sim.sv =====
// Top level: sequencer, LRU update, counters and output register of the cache tag store.
// A load or store passes through the read, scan and update states; the scan steps
// through the W ways in use with one shared tag comparator. A modify starts a second
// lookup once its first result is committed. Input is ready only in the idle state.
// Reset zeroes counters, set-index and offset bits and sets ways in use to one; a
// clearing pass after reset zeroes the valid bits, one set per cycle, with input not ready.
module set_assoc_cache_lru_sim (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sacl_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sacl_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sacl_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [SETB_W-1:0]     r_cfg_set_bits;
    logic [WAYS_CFG_W-1:0] r_cfg_ways;
    logic [OFFS_W-1:0]     r_cfg_offset;
    logic [1:0]            r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic                  r_second;
    logic [SET_W-1:0]      r_set;
    logic [ADDR_W-1:0]     r_tag;
    logic [WAY_W-1:0]      r_way;
    logic [CNT_W-1:0]      r_hits, n_hits;
    logic [CNT_W-1:0]      r_misses, n_misses;
    logic [CNT_W-1:0]      r_evicts, n_evicts;
    logic                  r_out_valid;
    t_out                  r_out;

    logic [SETB_W-1:0]     w_sb;
    logic [WAYS_CFG_W-1:0] w_nways;
    logic [SET_W-1:0]      w_set_mask;
    logic [ADDR_W-1:0]     w_shifted;
    logic [SET_W-1:0]      w_set;
    logic [SUM_W-1:0]      w_sum;
    logic [ADDR_W-1:0]     w_tag;
    logic                  w_in_xfer;
    logic                  w_slot_free;
    logic                  w_commit;
    logic                  w_scan_last;
    logic                  w_store_ready;
    logic [WAY_W-1:0]      w_sel;
    t_row                  w_rd_row;
    logic [MAX_WAYS-1:0]   w_rd_valid;
    t_scan_res             w_res;
    t_store_wr             w_wr;

    assign o_in_ready  = (r_state == S_IDLE) && w_store_ready;
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == S_UPDATE) && w_slot_free;

    always_comb begin
        w_sb = r_cfg_set_bits;
        if (32'(r_cfg_set_bits) > MAX_SET_BITS) begin
            w_sb = SETB_W'(MAX_SET_BITS);
        end
        w_nways = r_cfg_ways;
        if (r_cfg_ways == '0) begin
            w_nways = WAYS_CFG_W'(1);
        end else if (32'(r_cfg_ways) > MAX_WAYS) begin
            w_nways = WAYS_CFG_W'(MAX_WAYS);
        end
    end

    assign w_set_mask = (SET_W'(1) << w_sb) - SET_W'(1);
    assign w_shifted  = r_addr >> r_cfg_offset;
    assign w_set      = w_shifted[SET_W-1:0] & w_set_mask;
    assign w_sum      = {1'b0, r_cfg_offset} + SUM_W'(w_sb);
    assign w_tag      = w_sum[SUM_W-1] ? '0 : (r_addr >> w_sum[SUM_W-2:0]);
    assign w_scan_last = (WAYS_CFG_W'(r_way) == (w_nways - WAYS_CFG_W'(1)));

    sacl_tag_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (r_state == S_READ),
        .i_rd_set   (w_set),
        .i_wr       (w_wr),
        .o_rd_row   (w_rd_row),
        .o_rd_valid (w_rd_valid),
        .o_ready    (w_store_ready)
    );

    sacl_way_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (r_state == S_READ),
        .i_step  (r_state == S_SCAN),
        .i_way   (r_way),
        .i_key   (r_tag),
        .i_row   (w_rd_row),
        .i_valid (w_rd_valid),
        .o_res   (w_res)
    );

    always_comb begin
        w_sel = w_res.hit ? w_res.hit_way : (w_res.inv ? w_res.inv_way : w_res.victim);
        w_wr.en    = w_commit;
        w_wr.set   = r_set;
        w_wr.valid = w_rd_valid;
        w_wr.row   = w_rd_row;
        for (int j = 0; j < MAX_WAYS; j++) begin
            if ((WAYS_CFG_W'(j) < w_nways) && (WAY_W'(j) != w_sel) && w_rd_valid[j] &&
                (!w_res.hit || (w_rd_row.rank[j] < w_res.hit_rank)) &&
                (w_rd_row.rank[j] < RANK_MAX)) begin
                w_wr.row.rank[j] = w_rd_row.rank[j] + RANK_W'(1);
            end
        end
        w_wr.row.rank[w_sel] = '0;
        w_wr.valid[w_sel]    = 1'b1;
        if (!w_res.hit) begin
            w_wr.row.tag[w_sel] = r_tag;
        end
    end

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (w_res.hit) begin
            n_hits = (r_hits == CNT_MAX) ? r_hits : r_hits + CNT_W'(1);
        end else begin
            n_misses = (r_misses == CNT_MAX) ? r_misses : r_misses + CNT_W'(1);
            if (!w_res.inv) begin
                n_evicts = (r_evicts == CNT_MAX) ? r_evicts : r_evicts + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_in_data.op != OP_NONE)) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (w_slot_free) begin
                    n_state = ((r_op == OP_MODIFY) && !r_second) ? S_READ : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg_set_bits <= '0;
            r_cfg_ways     <= WAYS_CFG_W'(1);
            r_cfg_offset   <= '0;
            r_second       <= 1'b0;
            r_hits         <= '0;
            r_misses       <= '0;
            r_evicts       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_INDEX_BITS: r_cfg_set_bits <= i_cfg_data[SETB_W-1:0];
                    CFG_WAYS_IN_USE:    r_cfg_ways     <= i_cfg_data[WAYS_CFG_W-1:0];
                    CFG_OFFSET_BITS:    r_cfg_offset   <= i_cfg_data[OFFS_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_xfer) begin
                r_second <= 1'b0;
            end else if (w_commit) begin
                r_second <= 1'b1;
            end
            if (w_commit) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_evicts    <= n_evicts;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op   <= i_in_data.op;
            r_addr <= i_in_data.address;
        end
        if (r_state == S_READ) begin
            r_set <= w_set;
            r_tag <= w_tag;
            r_way <= '0;
        end else if (r_state == S_SCAN) begin
            r_way <= r_way + WAY_W'(1);
        end
        if (w_commit) begin
            r_out.outcome         <= w_res.hit ? OUT_HIT : (w_res.inv ? OUT_FILL : OUT_EVICT);
            r_out.final_of_run    <= (r_op != OP_MODIFY) || r_second;
            r_out.total_hits      <= n_hits;
            r_out.total_misses    <= n_misses;
            r_out.total_evictions <= n_evicts;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evicts <= r_misses)
        else $error("eviction count exceeds miss count");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.outcome == OUT_HIT)) |-> (o_out_data.total_hits != '0))
        else $error("hit result with zero hit count");

    a_ready_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> !o_in_ready || (r_op != OP_MODIFY) || r_second)
        else $error("modify released before its second lookup");

    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid)
        else $error("committed lookup did not load the output register");

endmodule

// ===== tb/tb_set_assoc_cache_lru_sim.sv =====
// Self-checking testbench for the set-associative LRU cache tag store.
module tb_set_assoc_cache_lru_sim;
    timeunit 1ns;
    timeprecision 1ps;

    import sacl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int NUM_PHASES = 9;

    class tag_store_tracker;
        bit                    valid_bits [NUM_SETS][MAX_WAYS];
        logic [ADDR_W-1:0]     tags       [NUM_SETS][MAX_WAYS];
        logic [RANK_W-1:0]     ranks      [NUM_SETS][MAX_WAYS];
        logic [CNT_W-1:0]      hits;
        logic [CNT_W-1:0]      misses;
        logic [CNT_W-1:0]      evictions;
        logic [SETB_W-1:0]     set_bits;
        logic [WAYS_CFG_W-1:0] ways;
        logic [OFFS_W-1:0]     offs;
        t_out                  expected_outcomes [$];
        int                    errors;

        function new();
            foreach (valid_bits[s, w]) begin
                valid_bits[s][w] = 1'b0;
                tags[s][w]       = '0;
                ranks[s][w]      = '0;
            end
            hits      = '0;
            misses    = '0;
            evictions = '0;
            set_bits  = '0;
            ways      = 4'd1;
            offs      = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SET_INDEX_BITS: set_bits = data[SETB_W-1:0];
                CFG_WAYS_IN_USE:    ways     = data[WAYS_CFG_W-1:0];
                CFG_OFFSET_BITS:    offs     = data[OFFS_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void promote(int s, int w, int nw, int limit);
            for (int j = 0; j < nw; j++) begin
                if (j != w && valid_bits[s][j] && int'(ranks[s][j]) < limit &&
                    ranks[s][j] < RANK_MAX)
                    ranks[s][j] = ranks[s][j] + 1'b1;
            end
            ranks[s][w] = '0;
        endfunction

        function logic [1:0] lookup(logic [ADDR_W-1:0] addr);
            int                sb;
            int                nw;
            int                ob;
            int                s;
            int                hit_way;
            int                free_way;
            int                victim;
            logic [ADDR_W-1:0] tag;
            sb = (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
            nw = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : int'(ways));
            ob = int'(offs);
            s = int'((addr >> ob) & ((64'd1 << sb) - 64'd1));
            tag = (ob + sb >= ADDR_W) ? '0 : (addr >> (ob + sb));
            hit_way = -1;
            free_way = -1;
            for (int j = 0; j < nw; j++) begin
                if (hit_way < 0 && valid_bits[s][j] && tags[s][j] == tag)
                    hit_way = j;
                if (free_way < 0 && !valid_bits[s][j])
                    free_way = j;
            end
            if (hit_way >= 0) begin
                hits = bump(hits);
                promote(s, hit_way, nw, int'(ranks[s][hit_way]));
                return OUT_HIT;
            end
            misses = bump(misses);
            if (free_way >= 0) begin
                valid_bits[s][free_way] = 1'b1;
                tags[s][free_way] = tag;
                promote(s, free_way, nw, 256);
                return OUT_FILL;
            end
            evictions = bump(evictions);
            victim = 0;
            for (int j = 1; j < nw; j++) begin
                if (ranks[s][j] > ranks[s][victim])
                    victim = j;
            end
            tags[s][victim] = tag;
            promote(s, victim, nw, 256);
            return OUT_EVICT;
        endfunction

        function void record(logic [1:0] outcome, logic last);
            t_out e;
            e.outcome         = outcome;
            e.final_of_run    = last;
            e.total_hits      = hits;
            e.total_misses    = misses;
            e.total_evictions = evictions;
            expected_outcomes.push_back(e);
        endfunction

        function void note_access(t_in item);
            case (item.op)
                OP_LOAD, OP_STORE: record(lookup(item.address), 1'b1);
                OP_MODIFY: begin
                    record(lookup(item.address), 1'b0);
                    record(lookup(item.address), 1'b1);
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction

        function void check_outcome(t_out got);
            t_out e;
            if (expected_outcomes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: outcome=%0d final=%0b",
                             got.outcome, got.final_of_run,
                             " hits=%0d misses=%0d evict=%0d", got.total_hits,
                             got.total_misses, got.total_evictions);
                return;
            end
            e = expected_outcomes.pop_front();
            if (got.outcome !== e.outcome || got.final_of_run !== e.final_of_run ||
                got.total_hits !== e.total_hits || got.total_misses !== e.total_misses ||
                got.total_evictions !== e.total_evictions) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp outcome=%0d final=%0b hits=%0d misses=%0d evict=%0d",
                             e.outcome, e.final_of_run, e.total_hits, e.total_misses,
                             e.total_evictions,
                             " | got outcome=%0d final=%0b hits=%0d misses=%0d evict=%0d",
                             got.outcome, got.final_of_run,
                             got.total_hits, got.total_misses, got.total_evictions);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out                  o_out_data;

    tag_store_tracker tracker = new();

    int                cur_sb = 0;
    int                cur_ob = 0;
    int                cur_nw = 1;
    int                results_seen = 0;
    logic [ADDR_W-1:0] tag_pool [10];
    logic [ADDR_W-1:0] set_pool [3];

    set_assoc_cache_lru_sim u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_in access(logic [1:0] op, logic [ADDR_W-1:0] addr);
        t_in a;
        a.op = op;
        a.address = addr;
        return a;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(int tag, int set, int off);
        return (64'(tag) << 6) | (64'(set) << 4) | 64'(off);
    endfunction

    function automatic t_in random_access();
        t_in               a;
        int                k;
        int                top;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] setv;
        logic [ADDR_W-1:0] low;
        k = $urandom_range(0, 99);
        top = (cur_nw + 1 > 9) ? 9 : cur_nw + 1;
        a.op = (k < 5) ? OP_NONE : 2'($urandom_range(0, 2));
        if (k >= 5 && k < 20) begin
            a.address = {$urandom, $urandom};
        end else begin
            tag  = tag_pool[$urandom_range(0, top)];
            setv = set_pool[$urandom_range(0, 2)] & ((64'd1 << cur_sb) - 64'd1);
            low  = {$urandom, $urandom} & ((64'd1 << cur_ob) - 64'd1);
            a.address = ((cur_ob + cur_sb >= ADDR_W) ? 64'd0 : (tag << (cur_ob + cur_sb))) |
                        (setv << cur_ob) | low;
        end
        return a;
    endfunction

    task automatic send_access(t_in item, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_access(item);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic apply_config(int sb_val, int ways_val, int ob_val);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  idxs [4];
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        idxs[0] = CFG_SET_INDEX_BITS;
        idxs[1] = CFG_WAYS_IN_USE;
        idxs[2] = CFG_OFFSET_BITS;
        idxs[3] = CFG_SPARE;
        vals[0] = {3'($urandom_range(0, 7)), 3'(sb_val)};
        vals[1] = {2'($urandom_range(0, 3)), 4'(ways_val)};
        vals[2] = 6'(ob_val);
        vals[3] = 6'($urandom);
        for (int r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idxs[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.write_reg(idxs[r], vals[r]);
        end
        i_cfg_valid <= 1'b0;
        cur_sb = (sb_val > MAX_SET_BITS) ? MAX_SET_BITS : sb_val;
        cur_ob = ob_val;
        cur_nw = (ways_val == 0) ? 1 : ((ways_val > MAX_WAYS) ? MAX_WAYS : ways_val);
    endtask

    initial begin
        int  stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = ((results_seen / 40) % 3 == 2) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_outcome(o_out_data);
            results_seen++;
        end
    end

    initial begin
        t_in dq [$];
        int  ph_sb   [NUM_PHASES];
        int  ph_ways [NUM_PHASES];
        int  ph_ob   [NUM_PHASES];
        bit  ph_keep [NUM_PHASES];
        int  gap;
        int  guard;
        ph_sb   = '{6, 6, 6, 7, 0, 3, 6, 1, -1};
        ph_ways = '{8, 2, 8, 15, 0, 2, 8, 5, -1};
        ph_ob   = '{6, 6, 6, 0, 63, 32, 58, 12, -1};
        ph_keep = '{0, 1, 1, 0, 0, 0, 0, 0, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one way, no set bits: every access maps to set zero
        dq.push_back(access(OP_LOAD,   64'h0));
        dq.push_back(access(OP_LOAD,   64'h0));
        dq.push_back(access(OP_STORE,  64'hFFFF_FFFF_FFFF_FFFF));
        dq.push_back(access(OP_MODIFY, 64'h0));
        dq.push_back(access(OP_NONE,   64'h5A5A_A5A5_0F0F_F0F0));
        dq.push_back(access(OP_LOAD,   64'h8000_0000_0000_0000));
        dq.push_back(access(OP_STORE,  64'h8000_0000_0000_0000));
        foreach (dq[i]) send_access(dq[i], $urandom_range(0, 17));

        apply_config(2, 4, 4);
        dq.delete();
        dq.push_back(access(OP_LOAD,   line_addr(1, 1, 0)));
        dq.push_back(access(OP_LOAD,   line_addr(2, 1, 15)));
        dq.push_back(access(OP_LOAD,   line_addr(3, 1, 7)));
        dq.push_back(access(OP_STORE,  line_addr(4, 1, 0)));
        dq.push_back(access(OP_LOAD,   line_addr(2, 1, 3)));
        dq.push_back(access(OP_LOAD,   line_addr(5, 1, 0)));
        dq.push_back(access(OP_LOAD,   line_addr(1, 1, 9)));
        dq.push_back(access(OP_MODIFY, line_addr(6, 2, 1)));
        dq.push_back(access(OP_STORE,  line_addr(2, 1, 0)));
        dq.push_back(access(OP_LOAD,   line_addr(2, 3, 0)));
        dq.push_back(access(OP_NONE,   line_addr(2, 1, 0)));
        dq.push_back(access(OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF));
        dq.push_back(access(OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFF0));
        foreach (dq[i]) send_access(dq[i], $urandom_range(0, 17));

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (ph_sb[p] < 0)
                apply_config($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 63));
            else
                apply_config(ph_sb[p], ph_ways[p], ph_ob[p]);
            if (!ph_keep[p]) begin
                foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
                foreach (set_pool[i]) set_pool[i] = 64'($urandom_range(0, NUM_SETS - 1));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 30)
                    wait_drained();
                gap = (p % 3 == 2) ? 0 : $urandom_range(0, 17);
                send_access(random_access(), gap);
            end
        end

        i_in_valid <= 1'b0;
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (tracker.pending() != 0 && guard < 20000);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
